FILE: design/obddtc_pkg.sv
// ----------------------------------------------------------------------------
// obddtc_pkg: shared types and constants for the distance/time counters
// Item and result payloads, counter set, operation and register codes, limits.
// ----------------------------------------------------------------------------
package obddtc_pkg;

  // operation codes carried in the input item
  localparam logic [1:0] OP_STEP    = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_RESTORE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_KM_CLR   = 2'd0;
  localparam logic [1:0] CFG_MIN_CLR  = 2'd1;
  localparam logic [1:0] CFG_KM_LAMP  = 2'd2;
  localparam logic [1:0] CFG_MIN_LAMP = 2'd3;

  localparam int HectoW = 29;
  localparam int SecW   = 32;
  localparam int OutW   = 16;

  localparam int HECTO_PER_KM = 10;
  localparam int SEC_PER_MIN  = 60;

  localparam logic [HectoW-1:0] DIST_CAP = 29'd429496729;
  localparam logic [OutW-1:0]   OUT_CAP  = 16'hFFFF;

  // counter values from which the clamped output saturates
  localparam logic [HectoW-1:0] KM_LIMIT  = 29'(HECTO_PER_KM * 65536);
  localparam logic [SecW-1:0]   MIN_LIMIT = 32'(SEC_PER_MIN * 65536);

  // reciprocals: x/10 = (x*RECIP_10)>>23 for x < 2^22,
  // x/60 = ((x>>2)*RECIP_15)>>24 for x>>2 < 2^20
  localparam logic [19:0] RECIP_10 = 20'd838861;
  localparam logic [20:0] RECIP_15 = 21'd1118482;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] odometer_hecto;
    logic        key_on;
    logic        engine_running;
    logic        lamp_on;
    logic        lamp_blink;
    logic        cycle_synced;
  } in_t;

  typedef struct packed {
    logic [15:0] km_since_clear;
    logic [15:0] minutes_since_clear;
    logic [15:0] km_lamp_on;
    logic [15:0] minutes_lamp_on;
  } out_t;

  typedef struct packed {
    logic [HectoW-1:0] hecto_clr;
    logic [SecW-1:0]   sec_clr;
    logic [HectoW-1:0] hecto_lamp;
    logic [SecW-1:0]   sec_lamp;
  } cnt_t;

endpackage

FILE: design/obddtc_dist_acc.sv
// ----------------------------------------------------------------------------
// obddtc_dist_acc: clamped distance accumulate
// Adds the signed odometer difference to a hectometre counter, held in [0, cap].
// ----------------------------------------------------------------------------
module obddtc_dist_acc (
  input  logic [obddtc_pkg::HectoW-1:0] acc_i,
  input  logic [15:0]                   sample_i,
  input  logic [15:0]                   prev_i,
  output logic [obddtc_pkg::HectoW-1:0] acc_o
);
  import obddtc_pkg::*;

  logic              fwd;
  logic [15:0]       diff;
  logic [HectoW-1:0] diff_ext;
  logic [HectoW-1:0] headroom;

  // magnitude and direction of the odometer change
  assign fwd      = (sample_i >= prev_i);
  assign diff     = fwd ? (sample_i - prev_i) : (prev_i - sample_i);
  assign diff_ext = {{(HectoW-16){1'b0}}, diff};
  assign headroom = DIST_CAP - diff_ext;

  // saturate at the cap going up, at zero going down
  always_comb begin
    if (fwd) begin
      acc_o = (acc_i < headroom) ? (acc_i + diff_ext) : DIST_CAP;
    end else begin
      acc_o = (acc_i <= diff_ext) ? '0 : (acc_i - diff_ext);
    end
  end

endmodule

FILE: design/obddtc_out_scale.sv
// ----------------------------------------------------------------------------
// obddtc_out_scale: counter to reported units
// Converts hectometres to km and seconds to minutes, each clamped to 16 bits.
// ----------------------------------------------------------------------------
module obddtc_out_scale (
  input  obddtc_pkg::cnt_t cnt_i,
  output obddtc_pkg::out_t res_o
);
  import obddtc_pkg::*;

  logic [39:0] km_clr_prod;
  logic [39:0] km_lamp_prod;
  logic [40:0] min_clr_prod;
  logic [40:0] min_lamp_prod;

  // reciprocal multiplies, valid below the clamp limits
  assign km_clr_prod   = 40'(cnt_i.hecto_clr[19:0]) * 40'(RECIP_10);
  assign km_lamp_prod  = 40'(cnt_i.hecto_lamp[19:0]) * 40'(RECIP_10);
  assign min_clr_prod  = 41'(cnt_i.sec_clr[21:2]) * 41'(RECIP_15);
  assign min_lamp_prod = 41'(cnt_i.sec_lamp[21:2]) * 41'(RECIP_15);

  // clamp select
  always_comb begin
    res_o.km_since_clear      = (cnt_i.hecto_clr >= KM_LIMIT) ? OUT_CAP
                                                              : km_clr_prod[38:23];
    res_o.km_lamp_on          = (cnt_i.hecto_lamp >= KM_LIMIT) ? OUT_CAP
                                                               : km_lamp_prod[38:23];
    res_o.minutes_since_clear = (cnt_i.sec_clr >= MIN_LIMIT) ? OUT_CAP
                                                             : min_clr_prod[39:24];
    res_o.minutes_lamp_on     = (cnt_i.sec_lamp >= MIN_LIMIT) ? OUT_CAP
                                                              : min_lamp_prod[39:24];
  end

endmodule

FILE: design/obd_distance_time_counters_unit.sv
// ----------------------------------------------------------------------------
// obd_distance_time_counters_unit: diagnostic distance and engine-time counters
// Path: counter register, then result register, to result valid. Throughput:
// one transaction per cycle unless out_stall_i holds a full result register.
// The counter update path (subtract, compare, saturate) feeds the counter register;
// the reciprocal multiply and clamp feed the result register.
// Reset clears all counters, the previous odometer sample and saved registers.
// ----------------------------------------------------------------------------
module obd_distance_time_counters_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  obddtc_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output obddtc_pkg::out_t  out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i
);
  import obddtc_pkg::*;

  logic [15:0] saved_km_clr_q, saved_min_clr_q, saved_km_lamp_q, saved_min_lamp_q;
  cnt_t        cnt_q, cnt_d;
  logic [15:0] prev_q, prev_d;
  logic        pend_q, pend_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q;
  out_t        scaled;

  logic              in_acc;
  logic              out_ready;
  logic              lamp_en;
  logic [HectoW-1:0] hecto_clr_upd, hecto_lamp_upd;

  // handshake: counter stage advances when the result register can take it
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = pend_q && !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  // saved registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saved_km_clr_q   <= '0;
      saved_min_clr_q  <= '0;
      saved_km_lamp_q  <= '0;
      saved_min_lamp_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KM_CLR:   saved_km_clr_q   <= cfg_wdata_i;
        CFG_MIN_CLR:  saved_min_clr_q  <= cfg_wdata_i;
        CFG_KM_LAMP:  saved_km_lamp_q  <= cfg_wdata_i;
        CFG_MIN_LAMP: saved_min_lamp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // distance updates share the previous sample
  obddtc_dist_acc u_dist_clr (
    .acc_i    (cnt_q.hecto_clr),
    .sample_i (in_data_i.odometer_hecto),
    .prev_i   (prev_q),
    .acc_o    (hecto_clr_upd)
  );

  obddtc_dist_acc u_dist_lamp (
    .acc_i    (cnt_q.hecto_lamp),
    .sample_i (in_data_i.odometer_hecto),
    .prev_i   (prev_q),
    .acc_o    (hecto_lamp_upd)
  );

  assign lamp_en = (in_data_i.lamp_on || in_data_i.lamp_blink) &&
                   in_data_i.cycle_synced && in_data_i.key_on;

  // counter next state
  always_comb begin
    cnt_d  = cnt_q;
    prev_d = prev_q;
    if (in_acc) begin
      unique case (in_data_i.operation)
        OP_STEP: begin
          if (in_data_i.key_on) begin
            cnt_d.hecto_clr = hecto_clr_upd;
            if (in_data_i.engine_running && (cnt_q.sec_clr != '1)) begin
              cnt_d.sec_clr = cnt_q.sec_clr + 32'd1;
            end
          end
          if (lamp_en) begin
            cnt_d.hecto_lamp = hecto_lamp_upd;
            if (cnt_q.sec_lamp != '1) begin
              cnt_d.sec_lamp = cnt_q.sec_lamp + 32'd1;
            end
          end
          prev_d = in_data_i.odometer_hecto;
        end
        OP_CLEAR: begin
          cnt_d = '0;
        end
        OP_RESTORE: begin
          // km * 10 as shift-add, minutes * 60 as shift-subtract
          cnt_d.hecto_clr  = ({13'd0, saved_km_clr_q} << 3) + ({13'd0, saved_km_clr_q} << 1);
          cnt_d.hecto_lamp = ({13'd0, saved_km_lamp_q} << 3) +
                             ({13'd0, saved_km_lamp_q} << 1);
          cnt_d.sec_clr    = ({16'd0, saved_min_clr_q} << 6) -
                             ({16'd0, saved_min_clr_q} << 2);
          cnt_d.sec_lamp   = ({16'd0, saved_min_lamp_q} << 6) -
                             ({16'd0, saved_min_lamp_q} << 2);
          prev_d           = '0;
        end
        default: ;
      endcase
    end
  end

  // stage flags
  always_comb begin
    pend_d      = in_acc ? 1'b1 : (out_ready ? 1'b0 : pend_q);
    out_valid_d = out_ready ? pend_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      prev_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      prev_q      <= prev_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  obddtc_out_scale u_scale (
    .cnt_i (cnt_q),
    .res_o (scaled)
  );

  always_ff @(posedge clk_i) begin
    if (out_ready && pend_q) begin
      out_q <= scaled;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // distance counters never pass the cap
  a_dist_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q.hecto_clr <= DIST_CAP) && (cnt_q.hecto_lamp <= DIST_CAP))
    else $error("distance counter above cap");

  // a clear transaction zeroes all four counters
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.operation == OP_CLEAR)) |=> (cnt_q == '0))
    else $error("counters not cleared");

  // restore drops the previous odometer sample
  a_restore_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.operation == OP_RESTORE)) |=> (prev_q == '0))
    else $error("previous sample not reset by restore");

  // input only stalls while a counter result waits behind a full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (pend_q && out_valid_q && out_stall_i))
    else $error("input stalled without back-pressure");

  // a pending counter result reaches the result register once it is free
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && out_ready) |=> out_valid_q)
    else $error("pending result lost");

endmodule
